/* rtl/pms_pkg.sv */
// Package for the pixel MISR signature block: register indexes, format codes,
// reset values and the MISR polynomial. No dependencies.
package pms_pkg;

	localparam int MAX_LINE_WIDTH_DEF = 8192;

	localparam logic [31:0] MISR_POLY = 32'h0FC2_2F87;

	typedef enum logic [1:0] {
		REG_PIXEL_FORMAT = 2'd0,
		REG_LINE_WIDTH   = 2'd1,
		REG_PAD_ENABLE   = 2'd2,
		REG_PAD_PERIOD   = 2'd3
	} reg_idx_t;

	localparam logic [1:0] FMT_RGB8   = 2'd0;
	localparam logic [1:0] FMT_RGBA10 = 2'd1;
	localparam logic [1:0] FMT_BGRA10 = 2'd2;
	// The spare format code unpacks like the 8-bit format.
	localparam logic [1:0] FMT_UNUSED = 2'd3;

	localparam logic [1:0]  PIXEL_FORMAT_RST = FMT_RGB8;
	localparam logic [13:0] LINE_WIDTH_RST   = 14'd128;
	localparam logic        PAD_ENABLE_RST   = 1'b0;
	localparam logic [15:0] PAD_PERIOD_RST   = 16'd1;

endpackage

/* rtl/pixel_misr_signature.sv */
// Top level of the pixel MISR signature block: APB register file, pixel
// unpacking, and one shared MISR step unit under a small sequencer.
// Depends on pms_pkg.
//
// Channel   Direction  Handshake                    Payload
// pixel     in         pixel_valid / pixel_stall    pixel_word[31:0], frame_last
// result    out        result_valid / result_stall  signature[31:0], line_padded
// config    in         APB psel/penable/pwrite      paddr[3:0], pwdata/prdata[31:0]
//
// For an ordinary pixel the MISR step unit folds in its surface word and the
// result goes to the output register at the same edge.
// A pixel that ends the pad_period-th line with padding enabled is followed by
// a padding line whose length is the clamped line width: the same step unit runs
// once per cycle with a zero surface word for the padding line.
// pixel_stall is high during a padding line and while a result waits in the
// output register under result_stall. Reset clears the signature, both
// position counters and the registers to their reset values.
module pixel_misr_signature #(
	parameter int MAX_LINE_WIDTH = pms_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel items
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [31:0] pixel_word,
	input  logic        frame_last,
	// result items
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] signature,
	output logic        line_padded
);

	// PW indexes a pixel within a line, WW holds the clamped width itself.
	localparam int PW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
	localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int CW = (WW > 14) ? WW : 14;

	typedef enum logic {
		ST_RUN,
		ST_PAD
	} state_t;

	// Configuration registers.
	logic [1:0]  pixel_format_q;
	logic [13:0] line_width_q;
	logic        pad_enable_q;
	logic [15:0] pad_period_q;

	// Block state.
	state_t        state_q;
	logic [31:0]   misr_q;
	logic [PW-1:0] pixel_in_line_q;
	logic [15:0]   lines_in_period_q;
	logic [WW-1:0] pad_cnt_q;
	logic          result_valid_q;
	logic [31:0]   signature_q;
	logic          line_padded_q;

	logic          cfg_write;
	logic          pixel_accept;
	logic [CW-1:0] width_wide;
	logic [WW-1:0] width_eff;
	logic [15:0]   period_eff;
	logic [29:0]   surface;
	logic [29:0]   surface_sel;
	logic [31:0]   misr_step;
	logic [WW-1:0] pixel_inc;
	logic          line_end;
	logic [16:0]   lines_inc;
	logic          pad_now;

	function automatic logic [9:0] widen8(input logic [7:0] b);
		return {b, b[7:6]};
	endfunction

	assign pready = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= pms_pkg::PIXEL_FORMAT_RST;
			line_width_q   <= pms_pkg::LINE_WIDTH_RST;
			pad_enable_q   <= pms_pkg::PAD_ENABLE_RST;
			pad_period_q   <= pms_pkg::PAD_PERIOD_RST;
		end else if (cfg_write) begin
			case (pms_pkg::reg_idx_t'(paddr[3:2]))
				pms_pkg::REG_PIXEL_FORMAT: pixel_format_q <= pwdata[1:0];
				pms_pkg::REG_LINE_WIDTH:   line_width_q   <= pwdata[13:0];
				pms_pkg::REG_PAD_ENABLE:   pad_enable_q   <= pwdata[0];
				pms_pkg::REG_PAD_PERIOD:   pad_period_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (pms_pkg::reg_idx_t'(paddr[3:2]))
			pms_pkg::REG_PIXEL_FORMAT: prdata = {30'd0, pixel_format_q};
			pms_pkg::REG_LINE_WIDTH:   prdata = {18'd0, line_width_q};
			pms_pkg::REG_PAD_ENABLE:   prdata = {31'd0, pad_enable_q};
			pms_pkg::REG_PAD_PERIOD:   prdata = {16'd0, pad_period_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// A width of zero counts as one; anything above the maximum is clamped.
	always_comb begin
		if (line_width_q == 14'd0) begin
			width_wide = CW'(1);
		end else if (CW'(line_width_q) > CW'(MAX_LINE_WIDTH)) begin
			width_wide = CW'(MAX_LINE_WIDTH);
		end else begin
			width_wide = CW'(line_width_q);
		end
		width_eff = WW'(width_wide);
	end

	assign period_eff = (pad_period_q == 16'd0) ? 16'd1 : pad_period_q;

	// Unpack the three components into the 30-bit surface word.
	always_comb begin
		case (pixel_format_q)
			pms_pkg::FMT_RGBA10:
				surface = {pixel_word[19:10], pixel_word[9:0], pixel_word[29:20]};
			pms_pkg::FMT_BGRA10:
				surface = {pixel_word[19:10], pixel_word[29:20], pixel_word[9:0]};
			default:
				surface = {widen8(pixel_word[15:8]), widen8(pixel_word[7:0]),
					widen8(pixel_word[23:16])};
		endcase
	end

	// The shared MISR step: a pixel in the run state, a zero word while padding.
	assign surface_sel = (state_q == ST_PAD) ? 30'd0 : surface;
	assign misr_step = {misr_q[30:0], 1'b0} ^ (misr_q[31] ? pms_pkg::MISR_POLY : 32'd0)
		^ {2'b00, surface_sel};

	assign pixel_stall = (state_q == ST_PAD) | (result_valid_q & result_stall);
	assign pixel_accept = pixel_valid & ~pixel_stall;

	// Line and period bookkeeping for the pixel on the input.
	assign pixel_inc = WW'(pixel_in_line_q) + WW'(1);
	assign line_end  = pixel_inc >= width_eff;
	assign lines_inc = {1'b0, lines_in_period_q} + 17'd1;
	assign pad_now   = line_end & pad_enable_q & (lines_inc >= {1'b0, period_eff});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_RUN;
			misr_q            <= 32'd0;
			pixel_in_line_q   <= '0;
			lines_in_period_q <= 16'd0;
			pad_cnt_q         <= '0;
			result_valid_q    <= 1'b0;
			signature_q       <= 32'd0;
			line_padded_q     <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (pixel_accept) begin
						misr_q <= misr_step;
						if (frame_last) begin
							pixel_in_line_q   <= '0;
							lines_in_period_q <= 16'd0;
						end else begin
							pixel_in_line_q <= line_end ? '0 : PW'(pixel_inc);
							if (line_end && pad_enable_q) begin
								lines_in_period_q <= pad_now ? 16'd0 : lines_inc[15:0];
							end
						end
						if (pad_now) begin
							state_q   <= ST_PAD;
							pad_cnt_q <= width_eff;
						end else begin
							result_valid_q <= 1'b1;
							signature_q    <= misr_step;
							line_padded_q  <= 1'b0;
						end
					end
				end
				ST_PAD: begin
					misr_q    <= misr_step;
					pad_cnt_q <= pad_cnt_q - WW'(1);
					if (pad_cnt_q == WW'(1)) begin
						state_q        <= ST_RUN;
						result_valid_q <= 1'b1;
						signature_q    <= misr_step;
						line_padded_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign signature    = signature_q;
	assign line_padded  = line_padded_q;

endmodule
